// File: sv/pq_adc_distance_accumulator_defines.svh
// assertion helpers used by the rtl file pqadc_back.sv
`ifndef PQ_ADC_DISTANCE_ACCUMULATOR_DEFINES_SVH
`define PQ_ADC_DISTANCE_ACCUMULATOR_DEFINES_SVH

// clocked property check, disabled while reset is asserted
`define PQADC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true at a clock edge
`define PQADC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `PQADC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: sv/pqadc_pkg.sv
`timescale 1ns / 1ps
package pqadc_pkg;

  // fixed field widths
  localparam int OpW       = 1;
  localparam int RowW      = 4;
  localparam int ColW      = 8;
  localparam int ValueW    = 31;
  localparam int CodeW     = 8;
  localparam int CountW    = 5;
  localparam int SumW      = 35;
  localparam int AddrMaxW  = 14;
  localparam int QueueDepth = 4;

  localparam logic [CountW-1:0] CountReset = CountW'(8);

  typedef enum logic [OpW-1:0] {
    OpWrite = 1'b0,
    OpCode  = 1'b1
  } opcode_e;

  // one request handed from the front to the back
  typedef struct packed {
    logic                is_write;
    logic                zero_add;
    logic                last;
    logic [AddrMaxW-1:0] addr;
    logic [ValueW-1:0]   value;
  } req_t;

endpackage

// File: sv/pqadc_in_if.sv
`timescale 1ns / 1ps
interface pqadc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pqadc_pkg::OpW-1:0]     opcode;
  logic [pqadc_pkg::RowW-1:0]    table_subquantizer;
  logic [pqadc_pkg::ColW-1:0]    table_centroid;
  logic [pqadc_pkg::ValueW-1:0]  table_value;
  logic [pqadc_pkg::CodeW-1:0]   code;

  modport source (
    output valid, opcode, table_subquantizer, table_centroid, table_value, code,
    input  ready
  );
  modport sink (
    input  valid, opcode, table_subquantizer, table_centroid, table_value, code,
    output ready
  );
endinterface

// File: sv/pqadc_out_if.sv
`timescale 1ns / 1ps
interface pqadc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pqadc_pkg::SumW-1:0]  distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

// File: sv/pqadc_cfg_if.sv
`timescale 1ns / 1ps
interface pqadc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pqadc_pkg::CountW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/pq_adc_distance_accumulator.sv
`timescale 1ns / 1ps
// pq asymmetric distance accumulator
// channels: in_i carries requests; opcode write fills one distance table entry
// (row table_subquantizer, column table_centroid) with table_value, opcode code
// supplies the next code byte of an encoded vector. cfg_i writes the
// sub-quantizer count (codes per vector). out_o carries one distance per vector.
// throughput: one request per cycle while the queue has room; the table has one access port, used once
// per request by the back part, and the sum adds once per cycle.
// path: the distance of a vector passes from the queue through the table read
// register and the add into the output register before it shows on out_o.
// reset: count returns to 8, position and sum to zero, the four-entry queue
// empties; table contents stay undefined until written, no clearing pass.
// receiver stall: the result waits in the output register; later codes keep
// flowing until a second finished sum is pending, then the queue fills and
// in_i.ready drops.
module pq_adc_distance_accumulator #(
  parameter int CENTROIDS_PER_SUBQ = 256,
  parameter int MAX_SUBQUANTIZERS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pqadc_in_if.sink    in_i,
  pqadc_cfg_if.sink   cfg_i,
  pqadc_out_if.source out_o
);

  localparam int TableDepth = MAX_SUBQUANTIZERS * CENTROIDS_PER_SUBQ;

  logic            push_valid, push_ready;
  logic            pop_valid, pop;
  pqadc_pkg::req_t push_req, pop_req;

  // front: accept and classify requests
  pqadc_front #(
    .CENTROIDS_PER_SUBQ (CENTROIDS_PER_SUBQ),
    .MAX_SUBQUANTIZERS  (MAX_SUBQUANTIZERS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_req_o   (push_req)
  );

  // decoupling queue
  pqadc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_req_o    (pop_req)
  );

  // back: table access and accumulation
  pqadc_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_req_i   (pop_req),
    .out_o       (out_o)
  );

endmodule

// File: sv/pqadc_ram.sv
`timescale 1ns / 1ps
module pqadc_ram #(
  parameter int Width = 31,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pqadc_front.sv
`timescale 1ns / 1ps
module pqadc_front #(
  parameter int CENTROIDS_PER_SUBQ = 256,
  parameter int MAX_SUBQUANTIZERS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pqadc_in_if.sink          in_i,
  pqadc_cfg_if.sink         cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output pqadc_pkg::req_t   push_req_o
);

  localparam int CountW = pqadc_pkg::CountW;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] pos_q, pos_d;
  logic [CountW-1:0] active_n;
  logic              is_code;
  logic              write_ok;
  logic              last;
  logic              in_fire;

  // sub-quantizer count register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pqadc_pkg::CountReset;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.data;
    end
  end

  // classify the request and build the table access
  always_comb begin
    active_n = count_q;
    if (count_q == '0) begin
      active_n = CountW'(1);
    end else if (32'(count_q) > MAX_SUBQUANTIZERS) begin
      active_n = CountW'(MAX_SUBQUANTIZERS);
    end

    is_code  = (in_i.opcode == pqadc_pkg::OpCode);
    write_ok = (32'(in_i.table_subquantizer) < MAX_SUBQUANTIZERS) &&
               (32'(in_i.table_centroid) < CENTROIDS_PER_SUBQ);
    last     = ({1'b0, pos_q} + (CountW + 1)'(1)) >= {1'b0, active_n};
    pos_d    = last ? '0 : pos_q + CountW'(1);

    push_req_o.is_write = !is_code;
    push_req_o.last     = last;
    push_req_o.value    = in_i.table_value;
    push_req_o.zero_add = !(32'(pos_q) < MAX_SUBQUANTIZERS) ||
                          !(32'(in_i.code) < CENTROIDS_PER_SUBQ);
    if (is_code) begin
      push_req_o.addr = pqadc_pkg::AddrMaxW'(32'(pos_q) * CENTROIDS_PER_SUBQ +
                                             32'(in_i.code));
    end else begin
      push_req_o.addr = pqadc_pkg::AddrMaxW'(
        32'(in_i.table_subquantizer) * CENTROIDS_PER_SUBQ + 32'(in_i.table_centroid));
    end
  end

  // out-of-range writes are taken and dropped
  assign in_i.ready   = push_ready_i;
  assign in_fire      = in_i.valid && push_ready_i;
  assign push_valid_o = in_i.valid && (is_code || write_ok);

  // position within the current vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire && is_code) begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: sv/pqadc_fifo.sv
`timescale 1ns / 1ps
module pqadc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  pqadc_pkg::req_t push_req_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output pqadc_pkg::req_t pop_req_o
);

  localparam int Depth = pqadc_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);

  pqadc_pkg::req_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PtrW + 1)'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_req_o    = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (PtrW + 1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (PtrW + 1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// File: sv/pqadc_back.sv
`timescale 1ns / 1ps
`include "pq_adc_distance_accumulator_defines.svh"
module pqadc_back #(
  parameter int TableDepth = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_o,
  input  pqadc_pkg::req_t pop_req_i,
  pqadc_out_if.source     out_o
);

  localparam int AddrW  = $clog2(TableDepth);
  localparam int SumW   = pqadc_pkg::SumW;
  localparam int ValueW = pqadc_pkg::ValueW;

  logic              ram_we, ram_re;
  logic [ValueW-1:0] rdata;
  logic [ValueW-1:0] add;
  logic [SumW:0]     sum_ext;
  logic [SumW-1:0]   sum_sat;
  logic [SumW-1:0]   sum_q;
  logic [SumW-1:0]   out_data_q;
  logic              out_valid_q;
  logic              s1_valid_q, s1_last_q, s1_zero_q;
  logic              advance;

  // distance table
  pqadc_ram #(
    .Width (ValueW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pop_req_i.addr[AddrW-1:0]),
    .wdata_i (pop_req_i.value),
    .re_i    (ram_re),
    .raddr_i (pop_req_i.addr[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // lookup stage advances unless a finished sum has nowhere to go
  always_comb begin
    advance = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
    pop_o   = pop_valid_i && (!s1_valid_q || advance);
    ram_we  = pop_o && pop_req_i.is_write;
    ram_re  = pop_o && !pop_req_i.is_write;
    add     = s1_zero_q ? '0 : rdata;
    sum_ext = {1'b0, sum_q} + (SumW + 1)'(add);
    sum_sat = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_re) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        sum_q <= s1_last_q ? '0 : sum_sat;
      end
      if (advance && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_last_q <= pop_req_i.last;
      s1_zero_q <= pop_req_i.zero_add;
    end
    if (advance && s1_last_q) begin
      out_data_q <= sum_sat;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.distance = out_data_q;

  `PQADC_ASSERT(a_sum_restart, clk_i, rst_ni, (advance && s1_last_q) |=> (sum_q == '0), "sum not cleared after a result")
  `PQADC_ASSERT(a_stall_no_pop, clk_i, rst_ni, (s1_valid_q && !advance) |-> !pop_o, "queue popped while lookup stalled")
  `PQADC_ASSERT(a_idle_pops, clk_i, rst_ni, (!s1_valid_q && pop_valid_i) |-> pop_o, "queue not drained while lookup idle")
  `PQADC_ASSERT_NEVER(a_one_port_op, clk_i, rst_ni, ram_we && ram_re, "table read and write together")

endmodule
